>>> rtl/section_table_address_translator_defines.svh
// Assertion helpers shared by the translator RTL.
`ifndef SECTION_TABLE_ADDRESS_TRANSLATOR_DEFINES_SVH
`define SECTION_TABLE_ADDRESS_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, checked on clk, masked during reset.
`define STAT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, masked during reset.
`define STAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/stat_pkg.sv
package stat_pkg;

	localparam int MAX_SECTIONS = 32;
	localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);
	localparam int OUT_IDX_W    = 5;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	typedef struct packed {
		logic [31:0] virt_addr;
		logic [31:0] raw_offset;
		logic [31:0] raw_size;
		logic        executable;
	} sect_entry_t;

	// read beat from the table, as seen by the scan unit
	typedef struct packed {
		logic             start;
		logic             rd_valid;
		logic [IDX_W-1:0] rd_idx;
	} scan_ctl_t;

	typedef struct packed {
		logic                 busy;
		logic [31:0]          offset_for_rva;
		logic [31:0]          end_for_offset;
		logic                 index_found;
		logic [OUT_IDX_W-1:0] section_index;
		logic [31:0]          rva_for_offset;
		logic [31:0]          first_start;
		logic [31:0]          first_end;
		logic [OUT_IDX_W-1:0] exec_index;
	} scan_res_t;

	// low bits of a table index, zero-extended when the table is small
	function automatic logic [OUT_IDX_W-1:0] idx_to_out(input logic [IDX_W-1:0] i);
		logic [IDX_W+OUT_IDX_W-1:0] wide;
		wide = {{OUT_IDX_W{1'b0}}, i};
		return wide[OUT_IDX_W-1:0];
	endfunction

endpackage

>>> rtl/section_table_address_translator.sv
// Clear, append and the spare code: result registered in the cycle after the beat is taken.
// Query: the table scan does one RAM read per section held, through the stage 2 registers and
//   the first-match accumulators; new beats are held off until its result is loaded.
// Other items: taken one per cycle while the result register is free.
// Reset: section count cleared, controller idle, result register empty;
//   the section RAM is not cleared and holds garbage until written.
`include "section_table_address_translator_defines.svh"

module section_table_address_translator (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] sect_virt_addr,
	input  logic [31:0] sect_raw_offset,
	input  logic [31:0] sect_raw_size,
	input  logic        sect_executable,
	input  logic [31:0] query_rva,
	input  logic [31:0] query_offset,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] offset_for_rva,
	output logic [31:0] end_for_offset,
	output logic        index_found,
	output logic [4:0]  section_index,
	output logic [31:0] rva_for_offset,
	output logic [31:0] first_start,
	output logic [31:0] first_end,
	output logic [4:0]  exec_index,
	output logic        load_rejected
);

	localparam int IDX_W = stat_pkg::IDX_W;
	localparam int CNT_W = stat_pkg::CNT_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(stat_pkg::MAX_SECTIONS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] count_q;   // sections held
	logic [CNT_W-1:0] n_q;       // snapshot of count for the running scan
	logic [CNT_W-1:0] rd_idx_q;  // next section to read
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic in_acc, out_free, full;
	logic wr_en, rd_en, scan_start, scan_end;
	logic load_imm, load_scan;

	stat_pkg::sect_entry_t wr_entry, rd_entry;
	stat_pkg::scan_ctl_t   scan_ctl;
	stat_pkg::scan_res_t   scan_res;

	// result register
	logic        out_valid_q;
	logic [31:0] offset_for_rva_q, end_for_offset_q, rva_for_offset_q;
	logic [31:0] first_start_q, first_end_q;
	logic        index_found_q, load_rejected_q;
	logic [4:0]  section_index_q, exec_index_q;

	// The result register frees up in the same cycle it is drained, so a new
	// beat can come in while the last result is being taken.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign full     = count_q >= MAX_CNT;

	// Writes only happen from idle and reads only while scanning, so the RAM
	// never sees a read and write in the same cycle.
	assign wr_en      = in_acc && (action == stat_pkg::ACT_APPEND) && !full;
	assign scan_start = in_acc && (action == stat_pkg::ACT_QUERY);
	assign load_imm   = in_acc && (action != stat_pkg::ACT_QUERY);
	assign rd_en      = (state_q == ST_SCAN) && (rd_idx_q != n_q);
	// done once every read has issued and the compare pipe is empty
	assign scan_end   = (state_q == ST_SCAN) && (rd_idx_q == n_q) && !rd_valid_s1
		&& !scan_res.busy;
	assign load_scan  = (state_q == ST_DONE) && out_free;

	always_comb begin
		wr_entry.virt_addr  = sect_virt_addr;
		wr_entry.raw_offset = sect_raw_offset;
		wr_entry.raw_size   = sect_raw_size;
		wr_entry.executable = sect_executable;
	end

	stat_ram #(
		.WIDTH($bits(stat_pkg::sect_entry_t)),
		.DEPTH(stat_pkg::MAX_SECTIONS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	always_comb begin
		scan_ctl.start    = scan_start;
		scan_ctl.rd_valid = rd_valid_s1;
		scan_ctl.rd_idx   = rd_idx_s1;
	end

	stat_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (scan_ctl),
		.entry        (rd_entry),
		.query_rva    (query_rva),
		.query_offset (query_offset),
		.res          (scan_res)
	);

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			n_q         <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (action)
							stat_pkg::ACT_CLEAR: begin
								count_q <= '0;
							end
							stat_pkg::ACT_APPEND: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							stat_pkg::ACT_QUERY: begin
								n_q      <= count_q;
								rd_idx_q <= '0;
								state_q  <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_imm || load_scan) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_imm) begin
			// clear, append and the unused code carry only the reject flag
			offset_for_rva_q <= '0;
			end_for_offset_q <= '0;
			index_found_q    <= 1'b0;
			section_index_q  <= '0;
			rva_for_offset_q <= '0;
			first_start_q    <= '0;
			first_end_q      <= '0;
			exec_index_q     <= '0;
			load_rejected_q  <= (action == stat_pkg::ACT_APPEND) && full;
		end else if (load_scan) begin
			offset_for_rva_q <= scan_res.offset_for_rva;
			end_for_offset_q <= scan_res.end_for_offset;
			index_found_q    <= scan_res.index_found;
			section_index_q  <= scan_res.section_index;
			rva_for_offset_q <= scan_res.rva_for_offset;
			first_start_q    <= scan_res.first_start;
			first_end_q      <= scan_res.first_end;
			exec_index_q     <= scan_res.exec_index;
			load_rejected_q  <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign offset_for_rva = offset_for_rva_q;
	assign end_for_offset = end_for_offset_q;
	assign index_found    = index_found_q;
	assign section_index  = section_index_q;
	assign rva_for_offset = rva_for_offset_q;
	assign first_start    = first_start_q;
	assign first_end      = first_end_q;
	assign exec_index     = exec_index_q;
	assign load_rejected  = load_rejected_q;

	`STAT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= MAX_CNT, "section count past capacity")
	`STAT_ASSERT_NOW(a_rw_apart, rd_en || rd_valid_s1, !wr_en, "table write during a scan")
	`STAT_ASSERT_NEXT(a_query_scans, scan_start, state_q == ST_SCAN, "query did not start a scan")
	`STAT_ASSERT_NEXT(a_read_bound, rd_en, rd_idx_q <= n_q, "scan read past section count")

endmodule

>>> rtl/stat_ram.sv
module stat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/stat_scan.sv
module stat_scan (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stat_pkg::scan_ctl_t    ctl,
	input  stat_pkg::sect_entry_t  entry,
	input  logic [31:0]            query_rva,
	input  logic [31:0]            query_offset,
	output stat_pkg::scan_res_t    res
);

	logic [31:0] rva_q, off_q;

	// stage 2: sums, differences and lower-bound compares
	logic                       valid_s2;
	logic [stat_pkg::IDX_W-1:0] idx_s2;
	logic [31:0]                va_s2, ro_s2, va_end_s2, re_s2, d_rva_s2, d_off_s2;
	logic                       ge_rva_s2, ge_off_s2, nz_s2, ex_s2;

	// first-match accumulators
	logic        hit_rva_q, hit_end_q, hit_idx_q, hit_first_q, hit_exec_q;
	logic [31:0] o_rva_q, o_end_q, o_back_q, o_fs_q, o_fe_q;
	logic [stat_pkg::IDX_W-1:0] o_idx_q, o_exec_q;

	logic m_rva, m_end, m_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctl.rd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rva_q <= query_rva;
			off_q <= query_offset;
		end
		if (ctl.rd_valid) begin
			idx_s2    <= ctl.rd_idx;
			va_s2     <= entry.virt_addr;
			ro_s2     <= entry.raw_offset;
			va_end_s2 <= entry.virt_addr + entry.raw_size;
			re_s2     <= entry.raw_offset + entry.raw_size;
			d_rva_s2  <= rva_q - entry.virt_addr;
			d_off_s2  <= off_q - entry.raw_offset;
			ge_rva_s2 <= rva_q >= entry.virt_addr;
			ge_off_s2 <= off_q >= entry.raw_offset;
			nz_s2     <= entry.raw_size != 32'd0;
			ex_s2     <= entry.executable;
		end
	end

	assign m_rva = ge_rva_s2 && (rva_q < va_end_s2);
	assign m_end = ge_off_s2 && (off_q < re_s2);
	assign m_idx = ge_off_s2 && (off_q <= re_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_rva_q   <= 1'b0;
			hit_end_q   <= 1'b0;
			hit_idx_q   <= 1'b0;
			hit_first_q <= 1'b0;
			hit_exec_q  <= 1'b0;
		end else if (ctl.start) begin
			hit_rva_q   <= 1'b0;
			hit_end_q   <= 1'b0;
			hit_idx_q   <= 1'b0;
			hit_first_q <= 1'b0;
			hit_exec_q  <= 1'b0;
		end else if (valid_s2) begin
			hit_rva_q   <= hit_rva_q | m_rva;
			hit_end_q   <= hit_end_q | m_end;
			hit_idx_q   <= hit_idx_q | m_idx;
			hit_first_q <= hit_first_q | nz_s2;
			hit_exec_q  <= hit_exec_q | ex_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			o_rva_q  <= stat_pkg::ALL_ONES;
			o_end_q  <= stat_pkg::ALL_ONES;
			o_back_q <= stat_pkg::ALL_ONES;
			o_fs_q   <= stat_pkg::ALL_ONES;
			o_fe_q   <= stat_pkg::ALL_ONES;
			o_idx_q  <= '0;
			o_exec_q <= '0;
		end else if (valid_s2) begin
			if (!hit_rva_q && m_rva) begin
				o_rva_q <= ro_s2 + d_rva_s2;
			end
			if (!hit_end_q && m_end) begin
				o_end_q <= re_s2;
			end
			if (!hit_idx_q && m_idx) begin
				o_idx_q  <= idx_s2;
				o_back_q <= d_off_s2 + va_s2;
			end
			if (!hit_first_q && nz_s2) begin
				o_fs_q <= ro_s2;
				o_fe_q <= re_s2;
			end
			if (!hit_exec_q && ex_s2) begin
				o_exec_q <= idx_s2;
			end
		end
	end

	always_comb begin
		res.busy           = valid_s2;
		res.offset_for_rva = o_rva_q;
		res.end_for_offset = o_end_q;
		res.index_found    = hit_idx_q;
		res.section_index  = stat_pkg::idx_to_out(o_idx_q);
		res.rva_for_offset = o_back_q;
		res.first_start    = o_fs_q;
		res.first_end      = o_fe_q;
		res.exec_index     = stat_pkg::idx_to_out(o_exec_q);
	end

endmodule

>>> sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// spare action code, the block answers it with an all-zero result
	localparam logic [1:0] ACT_IGNORED = 2'd3;

	localparam int QUIET_LIMIT     = 5000; // cycles with no beat on either side
	localparam int TAIL_CYCLES     = 60;   // a full-table query plus margin
	localparam int HOLD_OFF_CYCLES = 300;  // long output stall, fills the block

	// one input beat, field for field
	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] virt_addr;
		logic [31:0] raw_offset;
		logic [31:0] raw_size;
		logic        executable;
		logic [31:0] rva;
		logic [31:0] offset;
	} beat_t;

	// one result beat
	typedef struct packed {
		logic [31:0] offset_for_rva;
		logic [31:0] end_for_offset;
		logic        index_found;
		logic [4:0]  section_index;
		logic [31:0] rva_for_offset;
		logic [31:0] first_start;
		logic [31:0] first_end;
		logic [4:0]  exec_index;
		logic        load_rejected;
	} xlat_t;

	// ---------------------------------------------------------------
	// DUT ports; every input is known from time zero
	// ---------------------------------------------------------------
	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic        in_stall;
	logic [1:0]  action          = stat_pkg::ACT_CLEAR;
	logic [31:0] sect_virt_addr  = '0;
	logic [31:0] sect_raw_offset = '0;
	logic [31:0] sect_raw_size   = '0;
	logic        sect_executable = 1'b0;
	logic [31:0] query_rva       = '0;
	logic [31:0] query_offset    = '0;
	logic        out_valid;
	logic        out_stall       = 1'b0;
	logic [31:0] offset_for_rva;
	logic [31:0] end_for_offset;
	logic        index_found;
	logic [4:0]  section_index;
	logic [31:0] rva_for_offset;
	logic [31:0] first_start;
	logic [31:0] first_end;
	logic [4:0]  exec_index;
	logic        load_rejected;

	section_table_address_translator dut (.*);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow copy of the section table, updated when a beat is taken
	// ---------------------------------------------------------------
	logic [31:0] tbl_virt     [stat_pkg::MAX_SECTIONS];
	logic [31:0] tbl_raw_off  [stat_pkg::MAX_SECTIONS];
	logic [31:0] tbl_raw_size [stat_pkg::MAX_SECTIONS];
	logic        tbl_exec     [stat_pkg::MAX_SECTIONS];
	int          tbl_count = 0;

	xlat_t expected_results[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_cycles    = 0;
	int errors         = 0;

	// run statistics for the closing summary
	int n_clears = 0, n_appends = 0, n_refused = 0, n_queries = 0;
	int n_index_hits = 0, n_rva_hits = 0, n_ignored = 0, input_held = 0;

	// Updates the shadow table for one taken beat and returns the result it
	// must produce. Scans are first-match in table order; sums wrap at 32 bits.
	function automatic xlat_t table_response(input beat_t b);
		xlat_t       r;
		logic [31:0] va, ro, rs, re, va_end;
		bit          hit_rva, hit_end, hit_idx, hit_first, hit_exec;
		r         = '0;
		hit_rva   = 1'b0;
		hit_end   = 1'b0;
		hit_idx   = 1'b0;
		hit_first = 1'b0;
		hit_exec  = 1'b0;
		case (b.action)
		stat_pkg::ACT_CLEAR: tbl_count = 0;
		stat_pkg::ACT_APPEND: begin
			if (tbl_count >= stat_pkg::MAX_SECTIONS) begin
				r.load_rejected = 1'b1;
			end else begin
				tbl_virt[tbl_count]     = b.virt_addr;
				tbl_raw_off[tbl_count]  = b.raw_offset;
				tbl_raw_size[tbl_count] = b.raw_size;
				tbl_exec[tbl_count]     = b.executable;
				tbl_count++;
			end
		end
		stat_pkg::ACT_QUERY: begin
			r.offset_for_rva = stat_pkg::ALL_ONES;
			r.end_for_offset = stat_pkg::ALL_ONES;
			r.rva_for_offset = stat_pkg::ALL_ONES;
			r.first_start    = stat_pkg::ALL_ONES;
			r.first_end      = stat_pkg::ALL_ONES;
			for (int i = 0; i < tbl_count; i++) begin
				va     = tbl_virt[i];
				ro     = tbl_raw_off[i];
				rs     = tbl_raw_size[i];
				re     = ro + rs;
				va_end = va + rs;
				// RVA range is half-open over the raw size
				if (!hit_rva && b.rva >= va && b.rva < va_end) begin
					hit_rva          = 1'b1;
					r.offset_for_rva = ro + (b.rva - va);
				end
				if (!hit_end && b.offset >= ro && b.offset < re) begin
					hit_end          = 1'b1;
					r.end_for_offset = re;
				end
				// index and reverse lookup take the end bound inclusive
				if (!hit_idx && b.offset >= ro && b.offset <= re) begin
					hit_idx          = 1'b1;
					r.index_found    = 1'b1;
					r.section_index  = 5'(i);
					r.rva_for_offset = (b.offset - ro) + va;
				end
				if (!hit_first && rs != 32'd0) begin
					hit_first     = 1'b1;
					r.first_start = ro;
					r.first_end   = re;
				end
				if (!hit_exec && tbl_exec[i]) begin
					hit_exec     = 1'b1;
					r.exec_index = 5'(i);
				end
			end
		end
		default: ; // spare code: no state change, all-zero result
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus building blocks
	// ---------------------------------------------------------------
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
		0:       return 32'h0;
		1:       return stat_pkg::ALL_ONES;
		2:       return 32'h8000_0000;
		3:       return 32'h7FFF_FFFF;
		default: return $urandom();
		endcase
	endfunction

	// every field but the action random; callers overwrite what matters
	function automatic beat_t beat_of(input logic [1:0] act);
		beat_t b;
		b.action     = act;
		b.virt_addr  = pick_word();
		b.raw_offset = pick_word();
		b.raw_size   = pick_word();
		b.executable = 1'($urandom_range(0, 1));
		b.rva        = pick_word();
		b.offset     = pick_word();
		return b;
	endfunction

	function automatic beat_t section(input logic [31:0] va, input logic [31:0] ro,
			input logic [31:0] rs, input logic ex);
		beat_t b;
		b            = beat_of(stat_pkg::ACT_APPEND);
		b.virt_addr  = va;
		b.raw_offset = ro;
		b.raw_size   = rs;
		b.executable = ex;
		return b;
	endfunction

	function automatic beat_t lookup(input logic [31:0] rva, input logic [31:0] off);
		beat_t b;
		b        = beat_of(stat_pkg::ACT_QUERY);
		b.rva    = rva;
		b.offset = off;
		return b;
	endfunction

	// mostly a packed, overlapping layout; sometimes wild values that wrap
	function automatic beat_t make_append();
		logic [31:0] rs;
		if ($urandom_range(0, 9) < 2)
			return section(pick_word(), pick_word(), pick_word(), $urandom_range(0, 3) == 0);
		case ($urandom_range(0, 5))
		0:       rs = 32'h0;
		1, 2:    rs = 32'h200 * $urandom_range(1, 8);
		default: rs = $urandom_range(1, 32'h1000);
		endcase
		return section(32'h1000 * $urandom_range(0, 31), 32'h200 * $urandom_range(0, 63), rs,
			$urandom_range(0, 3) == 0);
	endfunction

	// an address on or next to a boundary of a section, or inside it
	function automatic logic [31:0] near_edge(input logic [31:0] base, input logic [31:0] size);
		case ($urandom_range(0, 6))
		0:       return base - 32'd1;
		1:       return base;
		2:       return base + 32'd1;
		3:       return base + size - 32'd1;
		4:       return base + size;
		5:       return base + size + 32'd1;
		default: return (size == 32'd0) ? base : base + ($urandom() % size);
		endcase
	endfunction

	function automatic beat_t make_query();
		int i, j;
		if (tbl_count == 0 || $urandom_range(0, 9) >= 8)
			return lookup(pick_word(), pick_word());
		i = $urandom_range(0, tbl_count - 1);
		j = $urandom_range(0, tbl_count - 1);
		return lookup(near_edge(tbl_virt[i], tbl_raw_size[i]),
			near_edge(tbl_raw_off[j], tbl_raw_size[j]));
	endfunction

	// ---------------------------------------------------------------
	// Input side: drive at negedge, take the beat at the first rising
	// edge with stall low. Valid stays high into the next beat unless
	// an idle cycle is drawn.
	// ---------------------------------------------------------------
	task automatic send_beat(input beat_t b);
		xlat_t want;
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		action          <= b.action;
		sect_virt_addr  <= b.virt_addr;
		sect_raw_offset <= b.raw_offset;
		sect_raw_size   <= b.raw_size;
		sect_executable <= b.executable;
		query_rva       <= b.rva;
		query_offset    <= b.offset;
		@(posedge clk);
		while (in_stall) begin
			input_held++;
			@(posedge clk);
		end
		want = table_response(b);
		expected_results.push_back(want);
		case (b.action)
		stat_pkg::ACT_CLEAR:  n_clears++;
		stat_pkg::ACT_APPEND: if (want.load_rejected) n_refused++; else n_appends++;
		stat_pkg::ACT_QUERY: begin
			n_queries++;
			if (want.index_found) n_index_hits++;
			if (want.offset_for_rva != stat_pkg::ALL_ONES) n_rva_hits++;
		end
		ACT_IGNORED: n_ignored++;
		endcase
	endtask

	// drop valid and hold off until every pending result is back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Output side: random stall, or a counted hold-off when requested
	// ---------------------------------------------------------------
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// result checker: every taken result beat against the oldest expectation
	initial begin
		xlat_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no item waiting for it");
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("offset_for_rva", want.offset_for_rva, offset_for_rva);
					check_field("end_for_offset", want.end_for_offset, end_for_offset);
					check_field("index_found", 32'(want.index_found), 32'(index_found));
					check_field("section_index", 32'(want.section_index),
						32'(section_index));
					check_field("rva_for_offset", want.rva_for_offset, rva_for_offset);
					check_field("first_start", want.first_start, first_start);
					check_field("first_end", want.first_end, first_end);
					check_field("exec_index", 32'(want.exec_index), 32'(exec_index));
					check_field("load_rejected", 32'(want.load_rejected),
						32'(load_rejected));
				end
			end
		end
	end

	// watchdog: too long with no beat taken on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat moved for %0d cycles, %0d results pending",
			QUIET_LIMIT, expected_results.size());
		$display("[section_table_address_translator] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// empty table right after reset: every miss value, spare action, clear
	task automatic test_empty_table();
		send_beat(lookup(32'h0, 32'h0));
		send_beat(lookup(stat_pkg::ALL_ONES, stat_pkg::ALL_ONES));
		send_beat(beat_of(ACT_IGNORED));
		send_beat(beat_of(stat_pkg::ACT_CLEAR));
		send_beat(lookup(32'h1000, 32'h400));
		wait_drained();
	endtask

	// hand-built table: empty section first, touching sections, wrapping one
	task automatic test_directed_sections();
		send_beat(beat_of(stat_pkg::ACT_CLEAR));
		send_beat(section(32'h1000, 32'h400, 32'h0, 1'b0));      // zero raw size
		send_beat(section(32'h1000, 32'h400, 32'h200, 1'b0));
		send_beat(section(32'h2000, 32'h600, 32'h200, 1'b1));    // first executable
		send_beat(section(32'hFFFF_FF00, 32'hFFFF_FF80, 32'h100, 1'b1)); // both ends wrap
		send_beat(section(stat_pkg::ALL_ONES, stat_pkg::ALL_ONES, stat_pkg::ALL_ONES, 1'b1));
		// empty section matches the inclusive index scan only
		send_beat(lookup(32'h1000, 32'h400));
		// last byte inside the first real section
		send_beat(lookup(32'h11FF, 32'h5FF));
		// one past the end: strict scans move on, inclusive scan stays
		send_beat(lookup(32'h1200, 32'h600));
		send_beat(lookup(32'h21FF, 32'h800));
		// wrapped section: its compares use the wrapped sums
		send_beat(lookup(32'hFFFF_FFF0, 32'hFFFF_FFC0));
		send_beat(lookup(32'h0, 32'h0));
		send_beat(lookup(stat_pkg::ALL_ONES, stat_pkg::ALL_ONES));
		send_beat(beat_of(ACT_IGNORED));
		send_beat(lookup(32'h0FFF, 32'h3FF));
		wait_drained();
	endtask

	// fill the table, overflow it, query it full, then clear it
	task automatic test_capacity();
		send_beat(beat_of(stat_pkg::ACT_CLEAR));
		repeat (stat_pkg::MAX_SECTIONS) send_beat(make_append());
		repeat (3) send_beat(make_append());          // refused, table unchanged
		repeat (4) send_beat(make_query());
		send_beat(lookup(pick_word(), pick_word()));
		send_beat(beat_of(stat_pkg::ACT_CLEAR));
		send_beat(make_query());
		wait_drained();
	endtask

	// long output hold-off while beats keep coming, so the input stalls
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_cycles = HOLD_OFF_CYCLES;
		send_beat(beat_of(stat_pkg::ACT_CLEAR));
		repeat (10) send_beat(make_append());
		repeat (30) begin
			if ($urandom_range(0, 3) == 0)
				send_beat(make_append());
			else
				send_beat(make_query());
		end
		wait_drained();
	endtask

	// mostly well-formed sequences (clear, appends, queries near section
	// edges), the rest single beats with any action and random fields
	task automatic test_random_traffic(input int n_items, input int idle_pct,
			input int stall_pct);
		int    sent, k;
		beat_t b;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent           = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 8) begin
				send_beat(beat_of(stat_pkg::ACT_CLEAR));
				case ($urandom_range(0, 19))
				0, 1, 2:    k = $urandom_range(28, stat_pkg::MAX_SECTIONS + 2);
				3, 4, 5, 6: k = $urandom_range(7, 20);
				default:    k = $urandom_range(1, 6);
				endcase
				repeat (k) send_beat(make_append());
				sent += 1 + k;
				k = $urandom_range(1, 6);
				repeat (k) send_beat(make_query());
				sent += k;
			end else begin
				b = beat_of(2'($urandom_range(0, 3)));
				if (b.action == stat_pkg::ACT_QUERY)
					b = make_query();
				send_beat(b);
				sent++;
			end
		end
		wait_drained();
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_directed_sections();
		test_capacity();
		test_backpressure();
		test_random_traffic(400, 0, 0);
		test_random_traffic(400, 47, 0);
		test_random_traffic(400, 0, 47);
		test_random_traffic(400, 11, 11);

		// any late extra result beat shows up here as unexpected
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d queries (%0d index hits, %0d rva hits), %0d appends, %0d refused",
			n_queries, n_index_hits, n_rva_hits, n_appends, n_refused);
		$display("plus %0d clears, %0d spare-action beats; input held off %0d cycles",
			n_clears, n_ignored, input_held);
		if (errors == 0 && expected_results.size() == 0)
			$display("[section_table_address_translator] OK");
		else
			$display("[section_table_address_translator] ERROR");
		$finish;
	end

endmodule
